/* rtl/wide_divide_128_by_64_unit_defines.svh */
// assertion macros for the wide divider
`ifndef WIDE_DIVIDE_128_BY_64_UNIT_DEFINES_SVH
`define WIDE_DIVIDE_128_BY_64_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define WD128_ASSERT_IMPLY(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
		else $error("wd128 check failed");

// condition implies consequence in the next cycle
`define WD128_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
		else $error("wd128 check failed");

`endif

/* rtl/wd128_pkg.sv */
// shared constants and types for the wide divider
package wd128_pkg;

	// width of every data field on the channels
	localparam int FIELD_BITS = 64;

	// default working word width
	localparam int WORD_BITS_DEF = 64;

	// per-item control flags carried along the cell chain
	typedef struct packed {
		logic neg_num;
		logic neg_dvs;
		logic div_zero;
	} ctrl_t;

endpackage

/* rtl/wd128_if.sv */
// valid/ready channel interfaces for requests and results
interface wd128_in_if;
	logic                             valid;
	logic                             ready;
	logic                             action;
	logic [wd128_pkg::FIELD_BITS-1:0] dividend_high;
	logic [wd128_pkg::FIELD_BITS-1:0] dividend_low;
	logic [wd128_pkg::FIELD_BITS-1:0] divisor;

	modport source (output valid, action, dividend_high, dividend_low, divisor, input ready);
	modport sink (input valid, action, dividend_high, dividend_low, divisor, output ready);
endinterface

interface wd128_out_if;
	logic                             valid;
	logic                             ready;
	logic [wd128_pkg::FIELD_BITS-1:0] quotient;
	logic [wd128_pkg::FIELD_BITS-1:0] remainder;
	logic                             divide_by_zero;

	modport source (output valid, quotient, remainder, divide_by_zero, input ready);
	modport sink (input valid, quotient, remainder, divide_by_zero, output ready);
endinterface

/* rtl/wd128_pre.sv */
// input stage: operand masking, sign detection and magnitude conversion
module wd128_pre #(
	parameter int W = wd128_pkg::WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  logic                             valid_in,
	input  logic                             action,
	input  logic [wd128_pkg::FIELD_BITS-1:0] dividend_high,
	input  logic [wd128_pkg::FIELD_BITS-1:0] dividend_low,
	input  logic [wd128_pkg::FIELD_BITS-1:0] divisor,
	output logic                             valid_s1,
	output wd128_pkg::ctrl_t                 ctrl_s1,
	output logic [2*W-1:0]                   num_s1,
	output logic [W-1:0]                     dvs_s1
);

	localparam logic [2*W-1:0] NUM_ONE = 1;
	localparam logic [W-1:0]   DVS_ONE = 1;

	logic [2*W-1:0]   num;
	logic [W-1:0]     dvs;
	wd128_pkg::ctrl_t ctrl;
	logic [2*W-1:0]   num_abs;
	logic [W-1:0]     dvs_abs;

	always_comb begin
		num           = {dividend_high[W-1:0], dividend_low[W-1:0]};
		dvs           = divisor[W-1:0];
		ctrl.neg_num  = action & num[2*W-1];
		ctrl.neg_dvs  = action & dvs[W-1];
		ctrl.div_zero = (dvs == '0);
		num_abs       = ctrl.neg_num ? (~num + NUM_ONE) : num;
		dvs_abs       = ctrl.neg_dvs ? (~dvs + DVS_ONE) : dvs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctrl_s1 <= ctrl;
			num_s1  <= num_abs;
			dvs_s1  <= dvs_abs;
		end
	end

endmodule

/* rtl/wd128_cell.sv */
// one restoring division step: develops one quotient bit per cycle while advance is high
module wd128_cell #(
	parameter int W = wd128_pkg::WORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             valid_in,
	input  wd128_pkg::ctrl_t ctrl_in,
	input  logic [W-1:0]     rem_in,
	input  logic [2*W-1:0]   num_in,
	input  logic [W-1:0]     dvs_in,
	output logic             valid_q,
	output wd128_pkg::ctrl_t ctrl_q,
	output logic [W-1:0]     rem_q,
	output logic [2*W-1:0]   num_q,
	output logic [W-1:0]     dvs_q
);

	logic [W-1:0]   shifted;
	logic [W:0]     diff;
	logic           take;
	logic [W-1:0]   rem_next;
	logic [2*W-1:0] num_next;

	// numerator shifts out at the top while quotient bits shift in at the bottom
	always_comb begin
		shifted  = {rem_in[W-2:0], num_in[2*W-1]};
		diff     = {rem_in[W-1], shifted} - {1'b0, dvs_in};
		take     = ~diff[W];
		rem_next = take ? diff[W-1:0] : shifted;
		num_next = {num_in[2*W-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctrl_q <= ctrl_in;
			rem_q  <= rem_next;
			num_q  <= num_next;
			dvs_q  <= dvs_in;
		end
	end

endmodule

/* rtl/wd128_post.sv */
// output stage: sign correction, zero-divisor handling and result register
module wd128_post #(
	parameter int W = wd128_pkg::WORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_in,
	input  wd128_pkg::ctrl_t ctrl_in,
	input  logic [W-1:0]     rem_in,
	input  logic [2*W-1:0]   num_in,
	output logic             advance,
	wd128_out_if.source      rsp
);

	localparam logic [W-1:0] ONE = 1;

	logic [W-1:0] quo;
	logic [W-1:0] quo_fix;
	logic [W-1:0] rem_fix;
	logic         valid_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] rem_q;
	logic         dz_q;

	always_comb begin
		quo     = num_in[W-1:0];
		quo_fix = (ctrl_in.neg_num ^ ctrl_in.neg_dvs) ? (~quo + ONE) : quo;
		rem_fix = ctrl_in.neg_num ? (~rem_in + ONE) : rem_in;
		if (ctrl_in.div_zero) begin
			quo_fix = '0;
			rem_fix = '0;
		end
	end

	// whole chain moves whenever the result slot is empty or being taken
	assign advance = ~valid_q | rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			quo_q <= quo_fix;
			rem_q <= rem_fix;
			dz_q  <= ctrl_in.div_zero;
		end
	end

	assign rsp.valid          = valid_q;
	assign rsp.quotient       = wd128_pkg::FIELD_BITS'(quo_q);
	assign rsp.remainder      = wd128_pkg::FIELD_BITS'(rem_q);
	assign rsp.divide_by_zero = dz_q;

endmodule

/* rtl/wide_divide_128_by_64_unit.sv */
// Divides a 2*WORD_BITS-bit dividend by a WORD_BITS-bit divisor, unsigned or
// two's-complement signed (truncating toward zero, remainder takes the
// dividend's sign), returning the low WORD_BITS quotient bits and the
// remainder; a zero divisor flags divide_by_zero with zero results. Bits of
// the 64-bit fields above WORD_BITS are ignored on input and read as zero on
// output. The datapath is a chain of 2*WORD_BITS restoring-division cells,
// one quotient bit per cell, between an operand stage and a result register,
// so one item is taken every cycle while the output is not held; a result
// is registered in the operand stage, in every cell and in the result
// register in turn. When a result waits in the output register and is not
// taken, the whole chain holds.
`include "wide_divide_128_by_64_unit_defines.svh"

module wide_divide_128_by_64_unit #(
	parameter int WORD_BITS = wd128_pkg::WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	wd128_in_if.sink    req,
	wd128_out_if.source rsp
);

	localparam int STEPS = 2 * WORD_BITS;

	logic                   advance;
	logic                   valid_c [0:STEPS];
	wd128_pkg::ctrl_t       ctrl_c  [0:STEPS];
	logic [WORD_BITS-1:0]   rem_c   [0:STEPS];
	logic [2*WORD_BITS-1:0] num_c   [0:STEPS];
	logic [WORD_BITS-1:0]   dvs_c   [0:STEPS];

	assign req.ready = advance;
	assign rem_c[0]  = '0;

	wd128_pre #(.W(WORD_BITS)) u_pre (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.valid_in      (req.valid),
		.action        (req.action),
		.dividend_high (req.dividend_high),
		.dividend_low  (req.dividend_low),
		.divisor       (req.divisor),
		.valid_s1      (valid_c[0]),
		.ctrl_s1       (ctrl_c[0]),
		.num_s1        (num_c[0]),
		.dvs_s1        (dvs_c[0])
	);

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		wd128_cell #(.W(WORD_BITS)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.valid_in (valid_c[i]),
			.ctrl_in  (ctrl_c[i]),
			.rem_in   (rem_c[i]),
			.num_in   (num_c[i]),
			.dvs_in   (dvs_c[i]),
			.valid_q  (valid_c[i+1]),
			.ctrl_q   (ctrl_c[i+1]),
			.rem_q    (rem_c[i+1]),
			.num_q    (num_c[i+1]),
			.dvs_q    (dvs_c[i+1])
		);
	end

	wd128_post #(.W(WORD_BITS)) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (valid_c[STEPS]),
		.ctrl_in  (ctrl_c[STEPS]),
		.rem_in   (rem_c[STEPS]),
		.num_in   (num_c[STEPS]),
		.advance  (advance),
		.rsp      (rsp)
	);

	// remainder magnitude out of the chain must be below the divisor magnitude
	`WD128_ASSERT_IMPLY(a_rem_below_dvs, clk, arst_n, valid_c[STEPS] && !ctrl_c[STEPS].div_zero, rem_c[STEPS] < dvs_c[STEPS])
	// zero divisor results carry zero data
	`WD128_ASSERT_IMPLY(a_dz_zero, clk, arst_n, rsp.valid && rsp.divide_by_zero, rsp.quotient == '0 && rsp.remainder == '0)
	// a held result freezes the last cell as well
	`WD128_ASSERT_NEXT(a_chain_hold, clk, arst_n, rsp.valid && !rsp.ready, $stable(valid_c[STEPS]))

endmodule
